[sv/tlhc_pkg.sv]
// Shared types and constants for the traffic light hue classifier.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tlhc_pkg;

  localparam int unsigned MAX_SIDE    = 1024;
  localparam int unsigned SIDE_W      = 11;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned TALLY_W     = 21;
  localparam int unsigned SUM_W       = TALLY_W + 2;
  localparam int unsigned SCORE_W     = 17;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned NUM_W       = TALLY_W + SCORE_W;
  localparam int unsigned SPAN_PROD_W = 2 * SIDE_W;
  localparam int unsigned LIT_PCT_W   = TALLY_W + 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MARGIN_W    = 7;

  localparam logic [TALLY_W-1:0]  TALLY_MAX    = '1;
  localparam logic [MARGIN_W-1:0] MARGIN_LIMIT = 7'd115;
  localparam logic [SIDE_W-1:0]   SIDE_LIMIT   = SIDE_W'(MAX_SIDE);
  localparam logic [SCORE_W-1:0]  ONE_Q16      = 17'd65536;
  localparam logic [6:0]          LIT_PCT      = 7'd100;
  localparam logic [TALLY_W-1:0]  MIN_LIT      = 21'd4;
  localparam logic [SIDE_W-1:0]   MIN_ROWS     = 11'd3;
  localparam logic [SIDE_W-1:0]   MIN_COLS     = 11'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SATURATION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_HUE_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RED_HUE_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_YELLOW_UPPER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GREEN_UPPER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_MARGIN   = 3'd6;

  typedef struct packed {
    logic [7:0]        hue;
    logic [7:0]        saturation;
    logic [7:0]        brightness;
    logic [POS_W-1:0]  pixel_row;
    logic [POS_W-1:0]  pixel_col;
    logic [SIDE_W-1:0] crop_height;
    logic [SIDE_W-1:0] crop_width;
    logic              last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [SCORE_W-1:0] red_score;
    logic [SCORE_W-1:0] yellow_score;
    logic [SCORE_W-1:0] green_score;
    logic               used_default;
  } score_t;

  typedef struct packed {
    logic [7:0]          min_brightness;
    logic [7:0]          min_saturation_level;
    logic [7:0]          red_hue_low_bound;
    logic [7:0]          red_hue_high_bound;
    logic [7:0]          yellow_hue_upper;
    logic [7:0]          green_hue_upper;
    logic [MARGIN_W-1:0] strip_margin_q8;
  } cfg_t;

  typedef struct packed {
    logic [TALLY_W-1:0] red;
    logic [TALLY_W-1:0] yellow;
    logic [TALLY_W-1:0] green;
    logic [TALLY_W-1:0] lit;
    logic [SIDE_W-1:0]  h_span;
    logic [SIDE_W-1:0]  w_span;
    logic               size_ok;
  } crop_sum_t;

endpackage

`default_nettype wire

[sv/tlhc_cfg_regs.sv]
// Configuration register file for the hue classifier.
// Depends on tlhc_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module tlhc_cfg_regs import tlhc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data,
  output cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_brightness       <= 8'd150;
      cfg.min_saturation_level <= 8'd100;
      cfg.red_hue_low_bound    <= 8'd10;
      cfg.red_hue_high_bound   <= 8'd160;
      cfg.yellow_hue_upper     <= 8'd35;
      cfg.green_hue_upper      <= 8'd90;
      cfg.strip_margin_q8      <= 7'd51;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_BRIGHTNESS: cfg.min_brightness       <= cfg_data;
        CFG_MIN_SATURATION: cfg.min_saturation_level <= cfg_data;
        CFG_RED_HUE_LOW:    cfg.red_hue_low_bound    <= cfg_data;
        CFG_RED_HUE_HIGH:   cfg.red_hue_high_bound   <= cfg_data;
        CFG_YELLOW_UPPER:   cfg.yellow_hue_upper     <= cfg_data;
        CFG_GREEN_UPPER:    cfg.green_hue_upper      <= cfg_data;
        CFG_STRIP_MARGIN:   cfg.strip_margin_q8      <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/tlhc_front.sv]
// Front end: takes pixel beats, applies the strip window and hue bounds,
// keeps the four saturating tallies and pushes one summary per crop.
// Depends on tlhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlhc_front import tlhc_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire pixel_t in_data,
  output logic        push,
  output crop_sum_t   push_data,
  input  wire logic   q_full
);

  function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] t);
    return (t == TALLY_MAX) ? t : t + 1'b1;
  endfunction

  // input stage
  logic              a_valid;
  pixel_t            a_pix;
  logic [SIDE_W-1:0] a_rows;
  logic [SIDE_W-1:0] a_cols;
  logic [SIDE_W-1:0] a_m;
  logic              a_trim_rows;

  logic [TALLY_W-1:0] red_tally, yellow_tally, green_tally, lit_tally;

  logic [SIDE_W-1:0]        rows_c, cols_c, short_c;
  logic [MARGIN_W-1:0]      q_c;
  logic [SIDE_W+MARGIN_W-1:0] m_prod;
  logic                     in_fire, a_fire;

  always_comb begin
    rows_c  = (in_data.crop_height > SIDE_LIMIT) ? SIDE_LIMIT : in_data.crop_height;
    cols_c  = (in_data.crop_width > SIDE_LIMIT) ? SIDE_LIMIT : in_data.crop_width;
    short_c = (cols_c > rows_c) ? rows_c : cols_c;
    q_c     = (cfg.strip_margin_q8 > MARGIN_LIMIT) ? MARGIN_LIMIT : cfg.strip_margin_q8;
    m_prod  = short_c * q_c;
  end

  assign in_stall = a_valid && a_pix.last_pixel && q_full;
  assign in_fire  = in_valid && !in_stall;
  assign a_fire   = a_valid && !(a_pix.last_pixel && q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_pix       <= in_data;
      a_rows      <= rows_c;
      a_cols      <= cols_c;
      a_m         <= SIDE_W'(m_prod >> 8);
      a_trim_rows <= cols_c > rows_c;
    end
  end

  // window and classification
  logic [SIDE_W-1:0] short_a, hi_raw, hi, span_trim;
  logic [SIDE_W-1:0] r0, r1, c0, c1, prow, pcol;
  logic              in_strip, lit;
  logic [TALLY_W-1:0] red_n, yellow_n, green_n, lit_n;

  always_comb begin
    short_a   = a_trim_rows ? a_rows : a_cols;
    hi_raw    = (short_a >= a_m) ? short_a - a_m : '0;
    hi        = (hi_raw < a_m + 1'b1) ? a_m + 1'b1 : hi_raw;
    span_trim = hi - a_m;
    r0 = a_trim_rows ? a_m : '0;
    r1 = a_trim_rows ? hi : a_rows;
    c0 = a_trim_rows ? '0 : a_m;
    c1 = a_trim_rows ? a_cols : hi;
    prow = SIDE_W'(a_pix.pixel_row);
    pcol = SIDE_W'(a_pix.pixel_col);
    in_strip = prow >= r0 && prow < r1 && prow < a_rows &&
               pcol >= c0 && pcol < c1 && pcol < a_cols;
    lit = in_strip && a_pix.brightness >= cfg.min_brightness &&
          a_pix.saturation >= cfg.min_saturation_level;

    red_n    = red_tally;
    yellow_n = yellow_tally;
    green_n  = green_tally;
    lit_n    = lit_tally;
    if (lit) begin
      lit_n = bump(lit_tally);
      if (a_pix.hue <= cfg.red_hue_low_bound || a_pix.hue >= cfg.red_hue_high_bound) begin
        red_n = bump(red_tally);
      end else if (a_pix.hue <= cfg.yellow_hue_upper) begin
        yellow_n = bump(yellow_tally);
      end else if (a_pix.hue < cfg.green_hue_upper) begin
        green_n = bump(green_tally);
      end
    end

    push_data.red     = red_n;
    push_data.yellow  = yellow_n;
    push_data.green   = green_n;
    push_data.lit     = lit_n;
    push_data.h_span  = a_trim_rows ? span_trim : a_rows;
    push_data.w_span  = a_trim_rows ? a_cols : span_trim;
    push_data.size_ok = a_rows >= MIN_ROWS && a_cols >= MIN_COLS;
  end

  assign push = a_fire && a_pix.last_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_tally    <= '0;
      yellow_tally <= '0;
      green_tally  <= '0;
      lit_tally    <= '0;
    end else if (a_fire) begin
      if (a_pix.last_pixel) begin
        red_tally    <= '0;
        yellow_tally <= '0;
        green_tally  <= '0;
        lit_tally    <= '0;
      end else begin
        red_tally    <= red_n;
        yellow_tally <= yellow_n;
        green_tally  <= green_n;
        lit_tally    <= lit_n;
      end
    end
  end

endmodule

`default_nettype wire

[sv/tlhc_queue.sv]
// Short queue of per-crop summaries between front and back.
// Depends on tlhc_pkg for crop_sum_t and the depth.
`timescale 1ns / 1ps
`default_nettype none

module tlhc_queue import tlhc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire crop_sum_t push_data,
  output logic           full,
  input  wire logic      pop,
  output logic           valid,
  output crop_sum_t      head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  crop_sum_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = count == (PTR_W + 1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/tlhc_divider.sv]
// Restoring divider, one quotient bit per cycle, for the Q1.16 shares.
// The quotient is known to fit SCORE_W bits. Depends on tlhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlhc_divider import tlhc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [SUM_W-1:0]   den,
  output logic                    done,
  output logic [SCORE_W-1:0]      quo
);

  localparam int unsigned STEP_W = $clog2(SCORE_W);

  logic               busy;
  logic [STEP_W-1:0]  steps;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   den_r;
  logic [SCORE_W-1:0] low;

  logic [SUM_W:0]   shifted;
  logic [SUM_W+1:0] diff;
  logic             ge;

  always_comb begin
    shifted = {rem, low[SCORE_W-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    ge      = !diff[SUM_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= SUM_W'(num[NUM_W-1:SCORE_W]);
      low   <= num[SCORE_W-1:0];
      den_r <= den;
      quo   <= '0;
      steps <= STEP_W'(SCORE_W - 1);
    end else if (busy) begin
      rem   <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
      low   <= {low[SCORE_W-2:0], 1'b0};
      quo   <= {quo[SCORE_W-2:0], ge};
      steps <= steps - 1'b1;
    end
  end

endmodule

`default_nettype wire

[sv/tlhc_back.sv]
// Back end: pops a crop summary, checks the fallback rules, runs the three
// share divisions and holds the result beat. Depends on tlhc_pkg, tlhc_divider.
`timescale 1ns / 1ps
`default_nettype none

module tlhc_back import tlhc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  wire crop_sum_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output score_t         out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_DIV,
    S_HOLD
  } state_t;

  typedef enum logic [1:0] {
    C_RED,
    C_YELLOW,
    C_GREEN
  } color_t;

  state_t                 state;
  color_t                 color;
  crop_sum_t              ent;
  logic [SPAN_PROD_W-1:0] strip_px;
  logic [LIT_PCT_W-1:0]   lit_pct;
  logic [SUM_W-1:0]       classified;

  logic               ok;
  logic               div_start, div_done;
  logic [TALLY_W-1:0] count_sel;
  logic [NUM_W-1:0]   div_num;
  logic [SCORE_W-1:0] div_quo;
  color_t             color_next;

  always_comb begin
    ok = ent.size_ok && lit_pct >= LIT_PCT_W'(strip_px) &&
         ent.lit >= MIN_LIT && classified != '0;
    q_pop = (state == S_IDLE) && q_valid;

    color_next = color;
    div_start  = 1'b0;
    if (state == S_CHECK && ok) begin
      color_next = C_RED;
      div_start  = 1'b1;
    end else if (state == S_DIV && div_done && color != C_GREEN) begin
      color_next = (color == C_RED) ? C_YELLOW : C_GREEN;
      div_start  = 1'b1;
    end

    unique case (color_next)
      C_RED:    count_sel = ent.red;
      C_YELLOW: count_sel = ent.yellow;
      C_GREEN:  count_sel = ent.green;
      default:  count_sel = ent.red;
    endcase
    div_num = {count_sel, {FRAC_W{1'b0}}} + NUM_W'(classified >> 1);
  end

  tlhc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (classified),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      color     <= C_RED;
      out_valid <= 1'b0;
    end else begin
      color <= color_next;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            ent   <= q_head;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          strip_px   <= ent.h_span * ent.w_span;
          lit_pct    <= ent.lit * LIT_PCT;
          classified <= SUM_W'(ent.red) + SUM_W'(ent.yellow) + SUM_W'(ent.green);
          state      <= S_CHECK;
        end
        S_CHECK: begin
          if (ok) begin
            out_data.used_default <= 1'b0;
            state                 <= S_DIV;
          end else begin
            out_data.red_score    <= ONE_Q16;
            out_data.yellow_score <= '0;
            out_data.green_score  <= '0;
            out_data.used_default <= 1'b1;
            out_valid             <= 1'b1;
            state                 <= S_HOLD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            unique case (color)
              C_RED:    out_data.red_score    <= div_quo;
              C_YELLOW: out_data.yellow_score <= div_quo;
              C_GREEN: begin
                out_data.green_score <= div_quo;
                out_valid            <= 1'b1;
                state                <= S_HOLD;
              end
              default: ;
            endcase
          end
        end
        S_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/traffic_light_hue_classifier_core.sv]
// Top level of the traffic light hue classifier: config registers, front,
// summary queue and back. Depends on tlhc_pkg and all tlhc_* modules.
//
//   channel  handshake             payload                 direction
//   in       in_valid / in_stall   in_data   (pixel_t)     pixel beat in
//   out      out_valid / out_stall out_data  (score_t)     one beat per crop
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data     register write
//
// The front takes one pixel beat per cycle while in_stall is low; a crop's tallies
// are pushed to the queue from the input stage that holds its last pixel. Per crop
// the back pops the summary, sets up, checks, then runs three share divisions
// (17 steps each) through one shared divider and outputs; a default crop skips them.
// The two-entry summary queue stalls input only when a last pixel meets it full.
// Reset is synchronous: tallies clear and the registers take their defaults.
`timescale 1ns / 1ps
`default_nettype none

module traffic_light_hue_classifier_core import tlhc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pixel_t               in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output score_t                    out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  cfg_t      cfg;
  logic      push, q_full, q_valid, q_pop;
  crop_sum_t push_data, q_head;

  tlhc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tlhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  tlhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/tb_traffic_light_hue_classifier_core.sv]
// Self-checking testbench for traffic_light_hue_classifier_core: drives pixel crops,
// rewrites the threshold registers between phases and checks each score beat.
// Depends on tlhc_pkg and the classifier RTL only.
`timescale 1ns / 1ps

module tb_traffic_light_hue_classifier_core;
  import tlhc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int LONG_HOLD      = 400;

  typedef enum logic [1:0] {CROP_WHOLE, CROP_CUT, CROP_OPEN} crop_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid;
  logic                 in_stall;
  pixel_t               in_data;
  logic                 out_valid;
  logic                 out_stall;
  score_t               out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  cfg_t               thresholds;
  logic [TALLY_W-1:0] exp_red;
  logic [TALLY_W-1:0] exp_yellow;
  logic [TALLY_W-1:0] exp_green;
  logic [TALLY_W-1:0] exp_lit;
  score_t             pending_scores[$];

  int  error_count    = 0;
  int  idle_cycles    = 0;
  int  pixels_offered = 0;
  int  hold_cycles    = 0;
  bit  tx_idle_on     = 1'b1;
  bit  rx_idle_on     = 1'b1;

  traffic_light_hue_classifier_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int draw_idle(input bit enabled);
    if (!enabled) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [TALLY_W-1:0] saturating_inc(input logic [TALLY_W-1:0] t);
    return (t == TALLY_MAX) ? t : t + 1'b1;
  endfunction

  function automatic logic [SCORE_W-1:0] q16_share(input logic [TALLY_W-1:0] count,
                                                   input longint unsigned total);
    longint unsigned num;
    num = (64'(count) << FRAC_W) + total / 2;
    return SCORE_W'(num / total);
  endfunction

  function automatic void tally_pixel(input pixel_t px);
    logic [SIDE_W-1:0]   rows;
    logic [SIDE_W-1:0]   cols;
    logic [MARGIN_W-1:0] q;
    int unsigned         m, r0, r1, c0, c1;
    longint unsigned     strip_px, classified;
    bit                  ok;
    score_t              s;
    rows = (px.crop_height > SIDE_LIMIT) ? SIDE_LIMIT : px.crop_height;
    cols = (px.crop_width > SIDE_LIMIT) ? SIDE_LIMIT : px.crop_width;
    q = (thresholds.strip_margin_q8 > MARGIN_LIMIT) ? MARGIN_LIMIT
                                                    : thresholds.strip_margin_q8;
    r0 = 0;
    r1 = 32'(rows);
    c0 = 0;
    c1 = 32'(cols);
    if (cols > rows) begin
      m = (32'(rows) * 32'(q)) >> 8;
      r0 = m;
      r1 = (rows >= m) ? rows - m : 0;
      if (r1 < m + 1) r1 = m + 1;
    end else begin
      m = (32'(cols) * 32'(q)) >> 8;
      c0 = m;
      c1 = (cols >= m) ? cols - m : 0;
      if (c1 < m + 1) c1 = m + 1;
    end
    if (px.pixel_row >= r0 && px.pixel_row < r1 && px.pixel_row < rows &&
        px.pixel_col >= c0 && px.pixel_col < c1 && px.pixel_col < cols &&
        px.brightness >= thresholds.min_brightness &&
        px.saturation >= thresholds.min_saturation_level) begin
      exp_lit = saturating_inc(exp_lit);
      if (px.hue <= thresholds.red_hue_low_bound || px.hue >= thresholds.red_hue_high_bound)
        exp_red = saturating_inc(exp_red);
      else if (px.hue <= thresholds.yellow_hue_upper)
        exp_yellow = saturating_inc(exp_yellow);
      else if (px.hue < thresholds.green_hue_upper)
        exp_green = saturating_inc(exp_green);
    end
    if (!px.last_pixel) return;
    strip_px = 64'(r1 - r0) * 64'(c1 - c0);
    classified = 64'(exp_red) + 64'(exp_yellow) + 64'(exp_green);
    ok = rows >= MIN_ROWS && cols >= MIN_COLS &&
         64'(exp_lit) * 64'(LIT_PCT) >= strip_px &&
         exp_lit >= MIN_LIT && classified != 0;
    if (ok) begin
      s.red_score    = q16_share(exp_red, classified);
      s.yellow_score = q16_share(exp_yellow, classified);
      s.green_score  = q16_share(exp_green, classified);
      s.used_default = 1'b0;
    end else begin
      s.red_score    = ONE_Q16;
      s.yellow_score = '0;
      s.green_score  = '0;
      s.used_default = 1'b1;
    end
    pending_scores.insert(pending_scores.size(), s);
    exp_red    = '0;
    exp_yellow = '0;
    exp_green  = '0;
    exp_lit    = '0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    score_t want;
    if (rst) begin
      thresholds = '{8'd150, 8'd100, 8'd10, 8'd160, 8'd35, 8'd90, 7'd51};
      exp_red    = '0;
      exp_yellow = '0;
      exp_green  = '0;
      exp_lit    = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_BRIGHTNESS: thresholds.min_brightness       = cfg_data;
          CFG_MIN_SATURATION: thresholds.min_saturation_level = cfg_data;
          CFG_RED_HUE_LOW:    thresholds.red_hue_low_bound    = cfg_data;
          CFG_RED_HUE_HIGH:   thresholds.red_hue_high_bound   = cfg_data;
          CFG_YELLOW_UPPER:   thresholds.yellow_hue_upper     = cfg_data;
          CFG_GREEN_UPPER:    thresholds.green_hue_upper      = cfg_data;
          CFG_STRIP_MARGIN:   thresholds.strip_margin_q8      = cfg_data[MARGIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) tally_pixel(in_data);
      if (out_valid && !out_stall) begin
        if (pending_scores.size() == 0) begin
          report_mismatch("score beat with no crop pending");
        end else begin
          want = pending_scores.pop_front();
          if (out_data.red_score !== want.red_score)
            report_mismatch($sformatf("red_score got %0d expected %0d",
                                      out_data.red_score, want.red_score));
          if (out_data.yellow_score !== want.yellow_score)
            report_mismatch($sformatf("yellow_score got %0d expected %0d",
                                      out_data.yellow_score, want.yellow_score));
          if (out_data.green_score !== want.green_score)
            report_mismatch($sformatf("green_score got %0d expected %0d",
                                      out_data.green_score, want.green_score));
          if (out_data.used_default !== want.used_default)
            report_mismatch($sformatf("used_default got %0b expected %0b",
                                      out_data.used_default, want.used_default));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Score sink: random stall per beat, long hold on request.
  initial begin : score_sink
    int wait_n;
    out_stall = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_cycles != 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end else begin
        wait_n = draw_idle(rx_idle_on);
        if (wait_n != 0) begin
          out_stall <= 1'b1;
          do @(posedge clk); while (!out_valid);
          repeat (wait_n - 1) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic pixel_t make_pixel(input logic [7:0] hue, input logic [7:0] sat,
                                        input logic [7:0] val, input logic [POS_W-1:0] row,
                                        input logic [POS_W-1:0] col,
                                        input logic [SIDE_W-1:0] h,
                                        input logic [SIDE_W-1:0] w, input logic last);
    pixel_t p;
    p = '{hue, sat, val, row, col, h, w, last};
    return p;
  endfunction

  function automatic logic [7:0] draw_level(input bit lit, input logic [7:0] floor);
    if (lit) return 8'($urandom_range(floor, 255));
    if (floor == 0) return 8'd0;
    return 8'($urandom_range(0, floor - 1));
  endfunction

  function automatic int draw_side();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 12);
  endfunction

  task automatic send_pixel(input pixel_t px);
    int gap;
    gap = draw_idle(tx_idle_on);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    pixels_offered++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_crop(input int h, input int w, input int lit_pct,
                           input crop_mode_t mode);
    int     total, n_send;
    bit     lit;
    logic [7:0] bound;
    pixel_t px;
    total  = h * w;
    n_send = total;
    if (mode == CROP_CUT && total > 1) n_send = $urandom_range(1, total - 1);
    for (int k = 0; k < n_send; k++) begin
      lit = $urandom_range(0, 99) < lit_pct;
      case ($urandom_range(0, 3))
        0: bound = thresholds.red_hue_low_bound;
        1: bound = thresholds.red_hue_high_bound;
        2: bound = thresholds.yellow_hue_upper;
        default: bound = thresholds.green_hue_upper;
      endcase
      case ($urandom_range(0, 3))
        0: px.hue = 8'($urandom_range(0, 255));
        1: px.hue = 8'($urandom_range(0, 179));
        default: px.hue = bound + 8'($urandom_range(0, 2)) - 8'd1;
      endcase
      if (lit || $urandom_range(0, 1)) begin
        px.saturation = draw_level(lit, thresholds.min_saturation_level);
        px.brightness = lit ? draw_level(1'b1, thresholds.min_brightness)
                            : 8'($urandom_range(0, 255));
      end else begin
        px.saturation = 8'($urandom_range(0, 255));
        px.brightness = draw_level(1'b0, thresholds.min_brightness);
      end
      px.pixel_row   = POS_W'(k / w);
      px.pixel_col   = POS_W'(k % w);
      px.crop_height = SIDE_W'(h);
      px.crop_width  = SIDE_W'(w);
      px.last_pixel  = (mode != CROP_OPEN) && (k == n_send - 1);
      send_pixel(px);
    end
  endtask

  task automatic run_crops(input int n_items, input int noise_pct);
    int     start;
    pixel_t px;
    start = pixels_offered;
    while (pixels_offered - start < n_items) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        if ($urandom_range(0, 1)) begin
          px.hue         = 8'($urandom_range(0, 255));
          px.saturation  = 8'($urandom_range(0, 255));
          px.brightness  = 8'($urandom_range(0, 255));
          px.pixel_row   = POS_W'($urandom_range(0, 1023));
          px.pixel_col   = POS_W'($urandom_range(0, 1023));
          px.crop_height = SIDE_W'($urandom_range(0, 2047));
          px.crop_width  = SIDE_W'($urandom_range(0, 2047));
          px.last_pixel  = ($urandom_range(0, 7) == 0);
          send_pixel(px);
        end else begin
          send_crop(draw_side(), draw_side(), $urandom_range(0, 100),
                    $urandom_range(0, 1) ? CROP_CUT : CROP_OPEN);
        end
      end else begin
        send_crop(draw_side(), draw_side(),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(50, 100),
                  CROP_WHOLE);
      end
    end
    send_crop(draw_side(), draw_side(), $urandom_range(40, 100), CROP_WHOLE);
  endtask

  // Drop input valid, wait for every pending score beat, then let the back end drain.
  task automatic settle_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_thresholds(input logic [7:0] bright, input logic [7:0] sat,
                                    input logic [7:0] red_lo, input logic [7:0] red_hi,
                                    input logic [7:0] yel_up, input logic [7:0] grn_up,
                                    input logic [7:0] margin);
    write_register(CFG_MIN_BRIGHTNESS, bright);
    write_register(CFG_MIN_SATURATION, sat);
    write_register(CFG_RED_HUE_LOW, red_lo);
    write_register(CFG_RED_HUE_HIGH, red_hi);
    write_register(CFG_YELLOW_UPPER, yel_up);
    write_register(CFG_GREEN_UPPER, grn_up);
    write_register(CFG_STRIP_MARGIN, margin);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_tiny_crops();
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 10'd0, 10'd0, 11'd1, 11'd1, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 10'd0, 10'd0, 11'd0, 11'd0, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 10'd0, 10'd0, 11'd2, 11'd2047, 1'b1));
  endtask

  task automatic test_hue_bounds();
    send_pixel(make_pixel(8'd10, 8'd255, 8'd255, 10'd0, 10'd0, 11'd3, 11'd3, 1'b0));
    send_pixel(make_pixel(8'd160, 8'd255, 8'd255, 10'd0, 10'd1, 11'd3, 11'd3, 1'b0));
    send_pixel(make_pixel(8'd200, 8'd255, 8'd255, 10'd0, 10'd2, 11'd3, 11'd3, 1'b0));
    send_pixel(make_pixel(8'd35, 8'd255, 8'd255, 10'd1, 10'd0, 11'd3, 11'd3, 1'b0));
    send_pixel(make_pixel(8'd89, 8'd255, 8'd255, 10'd1, 10'd1, 11'd3, 11'd3, 1'b0));
    send_pixel(make_pixel(8'd90, 8'd100, 8'd150, 10'd1, 10'd2, 11'd3, 11'd3, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd149, 10'd2, 10'd0, 11'd3, 11'd3, 1'b1));
  endtask

  task automatic test_field_extremes();
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 11'd0, 11'd0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023,
                          11'd2047, 11'd2047, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd255, 10'd512, 10'd512,
                          11'd1024, 11'd1024, 1'b1));
  endtask

  task automatic test_lit_floor();
    send_pixel(make_pixel(8'd0, 8'd200, 8'd200, 10'd0, 10'd0, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd20, 8'd200, 8'd200, 10'd0, 10'd1, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd60, 8'd200, 8'd200, 10'd1, 10'd0, 11'd3, 11'd2, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd200, 8'd200, 10'd0, 10'd0, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd20, 8'd200, 8'd200, 10'd0, 10'd1, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd60, 8'd200, 8'd200, 10'd1, 10'd0, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd61, 8'd200, 8'd200, 10'd1, 10'd1, 11'd3, 11'd2, 1'b1));
  endtask

  task automatic test_unclassified();
    send_pixel(make_pixel(8'd120, 8'd200, 8'd200, 10'd0, 10'd0, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd120, 8'd200, 8'd200, 10'd0, 10'd1, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd120, 8'd200, 8'd200, 10'd1, 10'd0, 11'd3, 11'd2, 1'b0));
    send_pixel(make_pixel(8'd120, 8'd200, 8'd200, 10'd1, 10'd1, 11'd3, 11'd2, 1'b1));
  endtask

  task automatic test_default_thresholds();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_crops(80, 0);
  endtask

  task automatic test_threshold_extremes();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    settle_block();
    program_thresholds(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    run_crops(40, 0);
    settle_block();
    program_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    run_crops(40, 0);
  endtask

  task automatic test_strip_margins();
    logic [7:0] margins[4];
    margins = '{8'd0, 8'd115, 8'd116, 8'd128};
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    foreach (margins[i]) begin
      settle_block();
      program_thresholds(8'd150, 8'd100, 8'd10, 8'd160, 8'd35, 8'd90, margins[i]);
      run_crops(20, 0);
    end
  endtask

  task automatic test_random_thresholds();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (4) begin
      settle_block();
      program_thresholds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
      run_crops(30, 0);
    end
  endtask

  task automatic test_broken_sequences();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    settle_block();
    program_thresholds(8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)), 8'd10,
                       8'd160, 8'd35, 8'd90, 8'($urandom_range(0, 115)));
    run_crops(80, 35);
  endtask

  // Hold the sink off while crops keep coming so the summary queue fills up.
  task automatic test_backpressure();
    settle_block();
    program_thresholds(8'd150, 8'd100, 8'd10, 8'd160, 8'd35, 8'd90, 8'd51);
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    hold_cycles = LONG_HOLD;
    repeat (30) send_crop($urandom_range(2, 3), 2, 100, CROP_WHOLE);
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
    run_crops(20, 0);
  endtask

  initial begin
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN_BRIGHTNESS;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_tiny_crops();
    test_hue_bounds();
    test_field_extremes();
    test_lit_floor();
    test_unclassified();
    test_default_thresholds();
    test_threshold_extremes();
    test_strip_margins();
    test_random_thresholds();
    test_broken_sequences();
    test_backpressure();
    settle_block();

    if (error_count == 0 && pending_scores.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
